@@ design/prqr_pkg.sv @@
// ----------------------------------------------------------------------------
// prqr_pkg
// Shared widths, microcode word layout, status flags and the control store
// for the rotating print queue rank unit.
// ----------------------------------------------------------------------------
`default_nettype none

package prqr_pkg;

  localparam int MAX_DOCS_DEF    = 64;
  localparam int PRIO_LEVELS_DEF = 16;

  // fixed field widths of the ports
  localparam int PRIO_W = 4;
  localparam int TGT_W  = 6;
  localparam int RANK_W = 7;

  localparam int STEP_W = 2;
  typedef logic [STEP_W-1:0] step_t;

  // microprogram addresses
  localparam step_t STEP_WAIT  = 2'd0;
  localparam step_t STEP_START = 2'd1;
  localparam step_t STEP_SCAN  = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  typedef enum logic [1:0] {
    COND_LAST     = 2'd0,
    COND_OOR      = 2'd1,
    COND_HIT      = 2'd2,
    COND_OUT_FREE = 2'd3
  } cond_t;

  // one control word: datapath strobes, branch condition, taken / fall-through
  typedef struct packed {
    logic  accept;
    logic  start;
    logic  scan;
    logic  emit;
    cond_t cond;
    step_t jump;
    step_t next;
  } ctrl_t;

  typedef struct packed {
    logic last_fire;
    logic tgt_oor;
    logic hit;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode_rom(input step_t addr);
    ctrl_t w;
    w = '0;
    unique case (addr)
      STEP_WAIT: begin
        w.accept = 1'b1;
        w.cond   = COND_LAST;
        w.jump   = STEP_START;
        w.next   = STEP_WAIT;
      end
      STEP_START: begin
        w.start = 1'b1;
        w.cond  = COND_OOR;
        w.jump  = STEP_EMIT;
        w.next  = STEP_SCAN;
      end
      STEP_SCAN: begin
        w.scan = 1'b1;
        w.cond = COND_HIT;
        w.jump = STEP_EMIT;
        w.next = STEP_SCAN;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_OUT_FREE;
        w.jump = STEP_WAIT;
        w.next = STEP_EMIT;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ design/prqr_ram.sv @@
// ----------------------------------------------------------------------------
// prqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module prqr_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

@@ design/prqr_useq.sv @@
// ----------------------------------------------------------------------------
// prqr_useq
// Microcode sequencer: step counter, control store lookup and branch select.
// ----------------------------------------------------------------------------
`default_nettype none

module prqr_useq import prqr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  step_t step_r, step_nxt;
  logic  take;

  assign ctrl = ucode_rom(step_r);

  always_comb begin
    unique case (ctrl.cond)
      COND_LAST:     take = stat.last_fire;
      COND_OOR:      take = stat.tgt_oor;
      COND_HIT:      take = stat.hit;
      COND_OUT_FREE: take = stat.out_free;
    endcase
    step_nxt = take ? ctrl.jump : ctrl.next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  a_hit_goes_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == STEP_SCAN && stat.hit) |=> step_r == STEP_EMIT)
    else $error("target hit did not branch to emit");

endmodule

`default_nettype wire

@@ design/prqr_dp.sv @@
// ----------------------------------------------------------------------------
// prqr_dp
// Datapath: document store, served mask, per-level tally, scan pointer and
// served counter, driven by the microcode strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module prqr_dp import prqr_pkg::*; #(
  parameter int MAX_DOCS    = MAX_DOCS_DEF,
  parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_t             ctrl,
  input  wire logic              in_fire,
  input  wire logic [PRIO_W-1:0] in_priority_req,
  input  wire logic              in_is_last,
  input  wire logic [TGT_W-1:0]  in_target_position,
  output logic                   tgt_oor,
  output logic                   hit,
  output logic      [RANK_W-1:0] rank
);

  localparam int IDX_W = $clog2(MAX_DOCS);
  localparam int CNT_W = $clog2(MAX_DOCS + 1);
  localparam int LVL_W = $clog2(PRIO_LEVELS);
  localparam int SAT_W = ((LVL_W > PRIO_W) ? LVL_W : PRIO_W) + 1;
  localparam int CMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;
  localparam int RK_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  served_r, served_nxt;
  logic [TGT_W-1:0]  target_r, target_nxt;
  logic [MAX_DOCS-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]  tally_r [PRIO_LEVELS];
  logic [CNT_W-1:0]  tally_nxt [PRIO_LEVELS];

  logic              load_en;
  logic [SAT_W-1:0]  pr_ext;
  logic [LVL_W-1:0]  pr_lvl;
  logic [LVL_W-1:0]  top_lvl;
  logic [LVL_W-1:0]  doc_lvl;
  logic              serve_ok;
  logic [CNT_W-1:0]  ptr_inc;

  assign load_en = in_fire && (count_r < CNT_W'(MAX_DOCS));

  // priorities beyond the last level saturate
  assign pr_ext = SAT_W'(in_priority_req);
  assign pr_lvl = (pr_ext >= SAT_W'(PRIO_LEVELS)) ? LVL_W'(PRIO_LEVELS - 1)
                                                   : pr_ext[LVL_W-1:0];

  // highest level that still has unserved documents
  always_comb begin
    top_lvl = '0;
    for (int lv = 0; lv < PRIO_LEVELS; lv++) begin
      if (tally_r[lv] != '0) begin
        top_lvl = LVL_W'(lv);
      end
    end
  end

  prqr_ram #(
    .WIDTH (LVL_W),
    .DEPTH (MAX_DOCS)
  ) u_doc_ram (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (pr_lvl),
    .rd_addr (ptr_nxt),
    .rd_data (doc_lvl)
  );

  assign serve_ok = ctrl.scan && !mask_r[ptr_r] && (doc_lvl == top_lvl);
  assign hit      = serve_ok && (CMP_W'(ptr_r) == CMP_W'(target_r));
  assign tgt_oor  = CMP_W'(target_r) >= CMP_W'(count_r);
  assign rank     = RANK_W'(RK_W'(served_r));
  assign ptr_inc  = CNT_W'(ptr_r) + CNT_W'(1);

  always_comb begin
    ptr_nxt    = ptr_r;
    served_nxt = served_r;
    count_nxt  = count_r;
    target_nxt = target_r;
    mask_nxt   = mask_r;

    // read address is fed from ptr_nxt so the registered data matches ptr_r in the scan step
    if (ctrl.start) begin
      ptr_nxt    = '0;
      served_nxt = '0;
    end else if (ctrl.scan) begin
      ptr_nxt = (ptr_inc >= count_r) ? '0 : ptr_inc[IDX_W-1:0];
    end

    if (serve_ok) begin
      served_nxt      = served_r + CNT_W'(1);
      mask_nxt[ptr_r] = 1'b1;
    end

    if (ctrl.emit) begin
      count_nxt = '0;
      mask_nxt  = '0;
    end else if (load_en) begin
      count_nxt = count_r + CNT_W'(1);
    end

    if (in_fire && in_is_last) begin
      target_nxt = in_target_position;
    end

    for (int lv = 0; lv < PRIO_LEVELS; lv++) begin
      tally_nxt[lv] = tally_r[lv];
      if (ctrl.emit) begin
        tally_nxt[lv] = '0;
      end else if (load_en && pr_lvl == LVL_W'(lv)) begin
        tally_nxt[lv] = tally_r[lv] + CNT_W'(1);
      end else if (serve_ok && doc_lvl == LVL_W'(lv)) begin
        tally_nxt[lv] = tally_r[lv] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      ptr_r    <= '0;
      served_r <= '0;
      target_r <= '0;
      mask_r   <= '0;
      for (int lv = 0; lv < PRIO_LEVELS; lv++) begin
        tally_r[lv] <= '0;
      end
    end else begin
      count_r  <= count_nxt;
      ptr_r    <= ptr_nxt;
      served_r <= served_nxt;
      target_r <= target_nxt;
      mask_r   <= mask_nxt;
      for (int lv = 0; lv < PRIO_LEVELS; lv++) begin
        tally_r[lv] <= tally_nxt[lv];
      end
    end
  end

  // while scanning the target is still unserved
  a_served_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.scan |-> served_r < count_r)
    else $error("served count ran past document count");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> !tgt_oor)
    else $error("target served although outside the queue");

endmodule

`default_nettype wire

@@ design/priority_rotating_queue_rank_unit.sv @@
// ----------------------------------------------------------------------------
// priority_rotating_queue_rank_unit
// Documents are loaded one word per cycle in queue order while in_stall is
// low; the word flagged last also carries the target index. After it, the
// unit serves the queue as a rotating queue (front served only if no
// unserved document has a higher priority) and returns the one-based rank of
// the target, or 0 if the target index is not below the document count.
// Service runs a start step, one scan step per queue position visited (at
// most about documents x distinct levels present), with one document store
// read per cycle, and an emit step that hands the rank to the output
// register once it is free. The next job's words are taken while a rank
// still waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_rotating_queue_rank_unit import prqr_pkg::*; #(
  parameter int MAX_DOCS    = MAX_DOCS_DEF,
  parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [PRIO_W-1:0] in_priority_req,
  input  wire logic              in_is_last,
  input  wire logic [TGT_W-1:0]  in_target_position,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [RANK_W-1:0] out_print_rank
);

  ctrl_t             ctrl;
  stat_t             stat;
  logic              in_fire;
  logic              out_free;
  logic              emit_fire;
  logic              tgt_oor;
  logic              hit;
  logic [RANK_W-1:0] rank;
  logic              out_valid_r, out_valid_nxt;
  logic [RANK_W-1:0] out_rank_r, out_rank_nxt;

  assign in_stall  = !ctrl.accept;
  assign in_fire   = in_valid && ctrl.accept;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = ctrl.emit && out_free;

  assign stat = '{last_fire: in_fire && in_is_last,
                  tgt_oor:   tgt_oor,
                  hit:       hit,
                  out_free:  out_free};

  prqr_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  prqr_dp #(
    .MAX_DOCS    (MAX_DOCS),
    .PRIO_LEVELS (PRIO_LEVELS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .in_fire            (in_fire),
    .in_priority_req    (in_priority_req),
    .in_is_last         (in_is_last),
    .in_target_position (in_target_position),
    .tgt_oor            (tgt_oor),
    .hit                (hit),
    .rank               (rank)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rank_nxt  = out_rank_r;
    if (emit_fire) begin
      out_valid_nxt = 1'b1;
      out_rank_nxt  = rank;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_rank_r <= out_rank_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_print_rank = out_rank_r;

  a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_valid_r)
    else $error("rank handed over but output register not loaded");

endmodule

`default_nettype wire
